/* src/i2c_light_sensor_master_defines.svh */
// ----------------------------------------------------------------------------
// I2C light sensor master: assertion macros
// Shared property forms for the checker of the bus master.
// ----------------------------------------------------------------------------
`ifndef I2C_LIGHT_SENSOR_MASTER_DEFINES_SVH
`define I2C_LIGHT_SENSOR_MASTER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define LSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2clsm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: package
// Shared types, codes and reset values of the bus master.
// ----------------------------------------------------------------------------
package i2clsm_pkg;

  // Register reset values
  localparam logic [6:0]  ADDR_RESET = 7'd35;
  localparam logic [9:0]  HALF_RESET = 10'd5;
  localparam logic [23:0] WAIT_RESET = 24'd10000;

  // Default depth of the request and result queues
  localparam int unsigned QUEUE_DEPTH = 2;

  // floor(raw*5/6) == (raw * 873815) >> 20 for every 16-bit raw value
  localparam logic [19:0] LUX_MULT  = 20'd873815;
  localparam int unsigned LUX_SHIFT = 20;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ADDR = 2'd0,
    CFG_HALF = 2'd1,
    CFG_WAIT = 2'd2
  } cfg_idx_e;

  // Command codes on the request port
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Bus phases
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START_A  = 5'd1,
    PH_START_B  = 5'd2,
    PH_WB_LOW   = 5'd3,
    PH_WB_HIGH  = 5'd4,
    PH_ACK_LOW  = 5'd5,
    PH_ACK_HIGH = 5'd6,
    PH_ACK_TAIL = 5'd7,
    PH_WAIT     = 5'd8,
    PH_RB_HIGH  = 5'd9,
    PH_RB_LOW   = 5'd10,
    PH_MA_LOW   = 5'd11,
    PH_MA_HIGH  = 5'd12,
    PH_MA_TAIL  = 5'd13,
    PH_STOP_PRE = 5'd14,
    PH_STOP_A   = 5'd15,
    PH_STOP_B   = 5'd16
  } phase_e;

  // Configuration seen by the bus engine
  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [9:0]  half_ticks;
    logic [23:0] wait_ticks;
  } cfg_t;

  // One classified tick request
  typedef struct packed {
    logic       start;
    logic       is_read;
    logic [7:0] cmd_byte;
    logic       sda_in;
  } tick_t;

  // One tick result
  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        busy;
    logic        done;
    logic        addr_acked;
    logic        cmd_acked;
    logic [15:0] raw_reading;
    logic [15:0] lux_value;
  } result_t;

endpackage

/* src/i2clsm_fifo.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: small queue
// Flop-based first-in first-out queue with registered entries.
// ----------------------------------------------------------------------------
module i2clsm_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/i2clsm_front.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: front end
// Accepts tick requests and classifies the command code.
// ----------------------------------------------------------------------------
module i2clsm_front (
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         command_i,
  input  logic [7:0]         command_byte_i,
  input  logic               sda_in_i,
  output logic               q_push_o,
  output i2clsm_pkg::tick_t  q_data_o
);

  // Accept whenever the queue has room
  assign q_push_o = push & ~full;

  // Classify: only write and read start a transaction, other codes are no-ops
  always_comb begin
    q_data_o.cmd_byte = command_byte_i;
    q_data_o.sda_in   = sda_in_i;
    unique case (command_i)
      i2clsm_pkg::CMD_WRITE: begin
        q_data_o.start   = 1'b1;
        q_data_o.is_read = 1'b0;
      end
      i2clsm_pkg::CMD_READ: begin
        q_data_o.start   = 1'b1;
        q_data_o.is_read = 1'b1;
      end
      default: begin
        q_data_o.start   = 1'b0;
        q_data_o.is_read = 1'b0;
      end
    endcase
  end

endmodule

/* src/i2clsm_back.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: bus engine
// Runs the bit-level phase sequencer, one tick per executed request.
// ----------------------------------------------------------------------------
module i2clsm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2clsm_pkg::cfg_t     cfg_i,
  input  logic                 tick_valid_i,
  input  i2clsm_pkg::tick_t    tick_i,
  output logic                 tick_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output i2clsm_pkg::result_t  res_o
);

  localparam int unsigned LuxW = 16;
  localparam int unsigned ProdW = LuxW + $bits(i2clsm_pkg::LUX_MULT);

  i2clsm_pkg::phase_e phase_q, phase_d;
  logic        is_read_q, is_read_d;
  logic [3:0]  bit_idx_q, bit_idx_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [23:0] delay_q, delay_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] raw_q, raw_d;
  logic [15:0] lux_q, lux_d;
  logic [1:0]  ack_q, ack_d;
  logic [15:0] lux_pre_q;

  logic             tick_go;
  logic             done;
  logic [23:0]      phase_len;
  logic             phase_end;
  logic [7:0]       tx_byte;
  logic             tx_bit;
  logic             scl_lvl, sda_lvl;
  logic [ProdW-1:0] lux_prod;

  // Execute one tick when a request waits and the result queue has room
  assign tick_go    = tick_valid_i & ~res_full_i;
  assign tick_pop_o = tick_go;
  assign res_push_o = tick_go;

  // Precompute lux from the latched bytes; they are final by the last read-byte low
  // phase, ahead of the master-ack low phase and the commit of the second data byte
  assign lux_prod = {raw_q[15:8], shift_q} * i2clsm_pkg::LUX_MULT;

  always_ff @(posedge clk_i) begin
    lux_pre_q <= lux_prod[i2clsm_pkg::LUX_SHIFT +: LuxW];
  end

  // Phase length and end-of-phase detect
  always_comb begin
    phase_len = (phase_q == i2clsm_pkg::PH_WAIT) ? cfg_i.wait_ticks
                                                 : {14'd0, cfg_i.half_ticks};
    if (phase_len == '0) begin
      phase_len = 24'd1;
    end
    phase_end = ({1'b0, delay_q} + 25'd1) >= {1'b0, phase_len};
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    is_read_d  = is_read_q;
    bit_idx_d  = bit_idx_q;
    byte_idx_d = byte_idx_q;
    delay_d    = delay_q;
    shift_d    = shift_q;
    raw_d      = raw_q;
    lux_d      = lux_q;
    ack_d      = ack_q;
    done       = 1'b0;
    if (tick_go) begin
      if (phase_q == i2clsm_pkg::PH_IDLE) begin
        // Launch a transaction
        if (tick_i.start) begin
          is_read_d  = tick_i.is_read;
          shift_d    = tick_i.cmd_byte;
          ack_d      = 2'b00;
          bit_idx_d  = 4'd0;
          byte_idx_d = 2'd0;
          delay_d    = 24'd0;
          phase_d    = i2clsm_pkg::PH_START_A;
        end
      end else if (!phase_end) begin
        delay_d = delay_q + 24'd1;
      end else begin
        delay_d = 24'd0;
        unique case (phase_q)
          i2clsm_pkg::PH_START_A: phase_d = i2clsm_pkg::PH_START_B;
          i2clsm_pkg::PH_START_B: phase_d = i2clsm_pkg::PH_WB_LOW;
          i2clsm_pkg::PH_WB_LOW:  phase_d = i2clsm_pkg::PH_WB_HIGH;
          i2clsm_pkg::PH_WB_HIGH: begin
            bit_idx_d = bit_idx_q + 4'd1;
            phase_d   = bit_idx_d[3] ? i2clsm_pkg::PH_ACK_LOW : i2clsm_pkg::PH_WB_LOW;
          end
          i2clsm_pkg::PH_ACK_LOW: phase_d = i2clsm_pkg::PH_ACK_HIGH;
          i2clsm_pkg::PH_ACK_HIGH: begin
            // Record slave acknowledge, never abort
            if (!tick_i.sda_in) begin
              if (byte_idx_q == 2'd0) begin
                ack_d[0] = 1'b1;
              end else begin
                ack_d[1] = 1'b1;
              end
            end
            phase_d = i2clsm_pkg::PH_ACK_TAIL;
          end
          i2clsm_pkg::PH_ACK_TAIL: begin
            if (byte_idx_q == 2'd0) begin
              byte_idx_d = 2'd1;
              bit_idx_d  = 4'd0;
              if (!is_read_q) begin
                phase_d = i2clsm_pkg::PH_WB_LOW;
              end else if (cfg_i.wait_ticks == '0) begin
                phase_d = i2clsm_pkg::PH_RB_HIGH;
              end else begin
                phase_d = i2clsm_pkg::PH_WAIT;
              end
            end else begin
              phase_d = i2clsm_pkg::PH_STOP_PRE;
            end
          end
          i2clsm_pkg::PH_WAIT: phase_d = i2clsm_pkg::PH_RB_HIGH;
          i2clsm_pkg::PH_RB_HIGH: begin
            shift_d = {shift_q[6:0], tick_i.sda_in};
            phase_d = i2clsm_pkg::PH_RB_LOW;
          end
          i2clsm_pkg::PH_RB_LOW: begin
            bit_idx_d = bit_idx_q + 4'd1;
            phase_d   = bit_idx_d[3] ? i2clsm_pkg::PH_MA_LOW : i2clsm_pkg::PH_RB_HIGH;
          end
          i2clsm_pkg::PH_MA_LOW: phase_d = i2clsm_pkg::PH_MA_HIGH;
          i2clsm_pkg::PH_MA_HIGH: begin
            // Commit the byte just read
            if (byte_idx_q == 2'd1) begin
              raw_d[15:8] = shift_q;
            end else begin
              raw_d[7:0] = shift_q;
              lux_d      = lux_pre_q;
            end
            phase_d = i2clsm_pkg::PH_MA_TAIL;
          end
          i2clsm_pkg::PH_MA_TAIL: begin
            if (byte_idx_q == 2'd1) begin
              byte_idx_d = 2'd2;
              bit_idx_d  = 4'd0;
              phase_d    = i2clsm_pkg::PH_RB_HIGH;
            end else begin
              phase_d = i2clsm_pkg::PH_STOP_PRE;
            end
          end
          i2clsm_pkg::PH_STOP_PRE: phase_d = i2clsm_pkg::PH_STOP_A;
          i2clsm_pkg::PH_STOP_A:   phase_d = i2clsm_pkg::PH_STOP_B;
          i2clsm_pkg::PH_STOP_B: begin
            phase_d = i2clsm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          default: phase_d = i2clsm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Line levels driven during the current tick
  always_comb begin
    tx_byte = (byte_idx_q == 2'd0) ? {cfg_i.dev_addr, is_read_q} : shift_q;
    tx_bit  = tx_byte[~bit_idx_q[2:0]];
    unique case (phase_q)
      i2clsm_pkg::PH_IDLE, i2clsm_pkg::PH_START_A: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      i2clsm_pkg::PH_START_B, i2clsm_pkg::PH_STOP_A: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b0;
      end
      i2clsm_pkg::PH_STOP_PRE: begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b0;
      end
      i2clsm_pkg::PH_WB_LOW: begin
        scl_lvl = 1'b0;
        sda_lvl = tx_bit;
      end
      i2clsm_pkg::PH_WB_HIGH: begin
        scl_lvl = 1'b1;
        sda_lvl = tx_bit;
      end
      i2clsm_pkg::PH_MA_LOW: begin
        scl_lvl = 1'b0;
        sda_lvl = (byte_idx_q != 2'd1);
      end
      i2clsm_pkg::PH_MA_HIGH: begin
        scl_lvl = 1'b1;
        sda_lvl = (byte_idx_q != 2'd1);
      end
      i2clsm_pkg::PH_ACK_HIGH, i2clsm_pkg::PH_RB_HIGH, i2clsm_pkg::PH_STOP_B: begin
        scl_lvl = 1'b1;
        sda_lvl = 1'b1;
      end
      default: begin
        scl_lvl = 1'b0;
        sda_lvl = 1'b1;
      end
    endcase
  end

  // Assemble the tick result
  always_comb begin
    res_o.scl_release = scl_lvl;
    res_o.sda_release = sda_lvl;
    res_o.busy        = (phase_d != i2clsm_pkg::PH_IDLE);
    res_o.done        = done;
    res_o.addr_acked  = ack_d[0];
    res_o.cmd_acked   = ack_d[1];
    res_o.raw_reading = raw_d;
    res_o.lux_value   = lux_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2clsm_pkg::PH_IDLE;
      is_read_q  <= 1'b0;
      bit_idx_q  <= 4'd0;
      byte_idx_q <= 2'd0;
      delay_q    <= 24'd0;
      shift_q    <= 8'd0;
      raw_q      <= 16'd0;
      lux_q      <= 16'd0;
      ack_q      <= 2'b00;
    end else begin
      phase_q    <= phase_d;
      is_read_q  <= is_read_d;
      bit_idx_q  <= bit_idx_d;
      byte_idx_q <= byte_idx_d;
      delay_q    <= delay_d;
      shift_q    <= shift_d;
      raw_q      <= raw_d;
      lux_q      <= lux_d;
      ack_q      <= ack_d;
    end
  end

endmodule

/* src/i2c_light_sensor_master.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: top level
// Tick-driven I2C master for command writes and two-byte measurement reads.
//
//   Channel   Handshake          Payload
//   --------  -----------------  ------------------------------------------
//   request   push / full        command_i, command_byte_i, sda_in_i
//   result    empty / pop        scl/sda release, busy, done, acks, raw, lux
//   config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One request is one bus tick; the engine executes one tick per cycle, so a
// new request is taken every cycle while results are drained.
// A pushed request reaches the result port through the request queue, then
// the bus engine writing the result queue; both queues are registered.
// A full result queue stalls the engine; requests then collect in the
// request queue until it fills and raises full.
// Reset empties both queues, clears the engine state and loads the config defaults.
// ----------------------------------------------------------------------------
module i2c_light_sensor_master #(
  parameter int unsigned QueueDepth = i2clsm_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  command_byte_i,
  input  logic        sda_in_i,
  // Result queue side
  output logic        empty,
  input  logic        pop,
  output logic        scl_release_o,
  output logic        sda_release_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        address_acked_o,
  output logic        command_acked_o,
  output logic [15:0] raw_reading_o,
  output logic [15:0] lux_value_o,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  i2clsm_pkg::cfg_t    cfg_q;
  i2clsm_pkg::tick_t   front_data, tick_data;
  i2clsm_pkg::result_t res_in, res_out;
  logic                front_push;
  logic                tick_empty, tick_pop;
  logic                res_push, res_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= i2clsm_pkg::ADDR_RESET;
      cfg_q.half_ticks <= i2clsm_pkg::HALF_RESET;
      cfg_q.wait_ticks <= i2clsm_pkg::WAIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2clsm_pkg::CFG_ADDR: cfg_q.dev_addr   <= cfg_wdata_i[6:0];
        i2clsm_pkg::CFG_HALF: cfg_q.half_ticks <= cfg_wdata_i[9:0];
        i2clsm_pkg::CFG_WAIT: cfg_q.wait_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2clsm_front u_front (
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .command_byte_i (command_byte_i),
    .sda_in_i       (sda_in_i),
    .q_push_o       (front_push),
    .q_data_o       (front_data)
  );

  // Request queue between front end and bus engine
  i2clsm_fifo #(
    .Width ($bits(i2clsm_pkg::tick_t)),
    .Depth (QueueDepth)
  ) u_tick_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_data),
    .full_o  (full),
    .pop_i   (tick_pop),
    .data_o  (tick_data),
    .empty_o (tick_empty)
  );

  i2clsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (~tick_empty),
    .tick_i       (tick_data),
    .tick_pop_o   (tick_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // Result queue toward the consumer
  i2clsm_fifo #(
    .Width ($bits(i2clsm_pkg::result_t)),
    .Depth (QueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign scl_release_o   = res_out.scl_release;
  assign sda_release_o   = res_out.sda_release;
  assign busy_res_o      = res_out.busy;
  assign done_res_o      = res_out.done;
  assign address_acked_o = res_out.addr_acked;
  assign command_acked_o = res_out.cmd_acked;
  assign raw_reading_o   = res_out.raw_reading;
  assign lux_value_o     = res_out.lux_value;

endmodule

/* src/i2clsm_checker.sv */
// ----------------------------------------------------------------------------
// I2C light sensor master: port checker
// Watches the result port for bus and result consistency.
// ----------------------------------------------------------------------------
`include "i2c_light_sensor_master_defines.svh"

module i2clsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        scl_release_o,
  input logic        sda_release_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [15:0] raw_reading_o,
  input logic [15:0] lux_value_o
);

  // A completed stop leaves the master idle
  `LSM_ASSERT_NOW(a_done_idle, clk_i, rst_ni, !empty && done_res_o, !busy_res_o, "done while busy")

  // Idle ticks and the stop tick release both lines
  `LSM_ASSERT_NOW(a_idle_lines, clk_i, rst_ni, !empty && (!busy_res_o || done_res_o), scl_release_o && sda_release_o, "lines held while idle")

  // Lux never exceeds five sixths of full scale
  `LSM_ASSERT_NOW(a_lux_range, clk_i, rst_ni, !empty, lux_value_o <= 16'd54612, "lux out of range")

  // A waiting result holds until taken
  `LSM_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(raw_reading_o), "result dropped")

endmodule

bind i2c_light_sensor_master i2clsm_checker u_i2clsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .scl_release_o (scl_release_o),
  .sda_release_o (sda_release_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o),
  .raw_reading_o (raw_reading_o),
  .lux_value_o   (lux_value_o)
);
